>>> rtl/b85_pkg.sv
package b85_pkg;

  localparam int unsigned QueueDepthDefault = 4;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_SHORT  = 2'd1;
  localparam logic [1:0] ST_SUFFIX = 2'd2;
  localparam logic [1:0] ST_ALIGN  = 2'd3;

  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_TWO   = 8'h32;

  localparam logic [2:0] BlockDigits = 3'd5;

  typedef struct packed {
    logic        ok;
    logic [6:0]  value;
  } digit_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  nbytes;
    logic        bare;
    logic        fin;
    logic [1:0]  status;
  } job_t;

  function automatic digit_t digit_of(input logic [7:0] c);
    digit_t r;
    r.ok    = 1'b1;
    r.value = 7'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.value = 7'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      r.value = 7'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r.value = 7'(c - 8'h3D);
    end else begin
      case (c)
        8'h21: r.value = 7'd62;
        8'h23: r.value = 7'd63;
        8'h24: r.value = 7'd64;
        8'h25: r.value = 7'd65;
        8'h26: r.value = 7'd66;
        8'h28: r.value = 7'd67;
        8'h29: r.value = 7'd68;
        8'h2A: r.value = 7'd69;
        8'h2B: r.value = 7'd70;
        8'h2D: r.value = 7'd71;
        8'h3B: r.value = 7'd72;
        8'h3C: r.value = 7'd73;
        8'h3D: r.value = 7'd74;
        8'h3E: r.value = 7'd75;
        8'h3F: r.value = 7'd76;
        8'h40: r.value = 7'd77;
        8'h5E: r.value = 7'd78;
        8'h5F: r.value = 7'd79;
        8'h60: r.value = 7'd80;
        8'h7B: r.value = 7'd81;
        8'h7C: r.value = 7'd82;
        8'h7D: r.value = 7'd83;
        8'h7E: r.value = 7'd84;
        default: r.ok = 1'b0;
      endcase
    end
    return r;
  endfunction

endpackage

>>> rtl/b85_front.sv
module b85_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_char_in,
  input  logic             in_frame_end,
  output logic             push_valid,
  input  logic             push_ready,
  output b85_pkg::job_t    push_job
);

  logic [7:0]  older_r, older_nxt;
  logic [7:0]  newer_r, newer_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [2:0]  ndig_r, ndig_nxt;
  logic        any_r, any_nxt;
  logic        inv_r, inv_nxt;

  b85_pkg::digit_t dig;
  logic        fold;
  logic        blk;
  logic [31:0] acc_f;
  logic [31:0] acc_mul;
  logic [2:0]  ndig_f;
  logic [1:0]  pad;
  logic [1:0]  st;
  logic        has_job;
  logic        take;

  assign in_ready = push_ready;
  assign take     = in_valid & in_ready;

  always_comb begin
    dig     = b85_pkg::digit_of(older_r);
    fold    = (cnt_r == 2'd2);
    acc_mul = (acc_r << 6) + (acc_r << 4) + (acc_r << 2) + acc_r;
    acc_f   = fold ? acc_mul + {25'd0, dig.ok ? dig.value : 7'd0} : acc_r;
    ndig_f  = fold ? ndig_r + 3'd1 : ndig_r;
    blk     = fold && (ndig_f == b85_pkg::BlockDigits);
    inv_nxt = inv_r | (fold & ~dig.ok);
    any_nxt = any_r | blk;
    acc_nxt = blk ? 32'd0 : acc_f;
    ndig_nxt = blk ? 3'd0 : ndig_f;

    pad = 2'd0;
    st  = b85_pkg::ST_OK;
    if (cnt_r == 2'd0) begin
      st = b85_pkg::ST_SHORT;
    end else begin
      if (newer_r != b85_pkg::CH_TILDE) st = b85_pkg::ST_SUFFIX;
      else if (in_char_in == b85_pkg::CH_TILDE) pad = 2'd0;
      else if (in_char_in == b85_pkg::CH_ZERO) pad = 2'd1;
      else if (in_char_in == b85_pkg::CH_ONE) pad = 2'd2;
      else if (in_char_in == b85_pkg::CH_TWO) pad = 2'd3;
      else st = b85_pkg::ST_SUFFIX;
      if (st == b85_pkg::ST_OK) begin
        if (ndig_nxt != 3'd0) st = b85_pkg::ST_ALIGN;
        else if (!any_nxt && pad != 2'd0) st = b85_pkg::ST_SUFFIX;
        else if (inv_nxt) st = b85_pkg::ST_ALIGN;
      end
    end

    push_job.word = acc_f;
    if (in_frame_end) begin
      has_job = 1'b1;
      push_job.fin = 1'b1;
      if (st == b85_pkg::ST_OK && blk) begin
        push_job.nbytes = 3'd4 - {1'b0, pad};
        push_job.bare   = 1'b0;
        push_job.status = b85_pkg::ST_OK;
      end else begin
        push_job.nbytes = 3'd1;
        push_job.bare   = 1'b1;
        push_job.status = st;
      end
    end else begin
      has_job = blk & ~inv_nxt;
      push_job.fin    = 1'b0;
      push_job.nbytes = 3'd4;
      push_job.bare   = 1'b0;
      push_job.status = b85_pkg::ST_OK;
    end

    older_nxt = newer_r;
    newer_nxt = in_char_in;
    cnt_nxt   = (cnt_r == 2'd2) ? cnt_r : cnt_r + 2'd1;
  end

  assign push_valid = take & has_job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      older_r <= 8'd0;
      newer_r <= 8'd0;
      cnt_r   <= 2'd0;
      acc_r   <= 32'd0;
      ndig_r  <= 3'd0;
      any_r   <= 1'b0;
      inv_r   <= 1'b0;
    end else if (take) begin
      if (in_frame_end) begin
        older_r <= 8'd0;
        newer_r <= 8'd0;
        cnt_r   <= 2'd0;
        acc_r   <= 32'd0;
        ndig_r  <= 3'd0;
        any_r   <= 1'b0;
        inv_r   <= 1'b0;
      end else begin
        older_r <= older_nxt;
        newer_r <= newer_nxt;
        cnt_r   <= cnt_nxt;
        acc_r   <= acc_nxt;
        ndig_r  <= ndig_nxt;
        any_r   <= any_nxt;
        inv_r   <= inv_nxt;
      end
    end
  end

endmodule

>>> rtl/b85_queue.sv
module b85_queue #(
  parameter int unsigned DEPTH = b85_pkg::QueueDepthDefault
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  b85_pkg::job_t    push_job,
  output logic             pop_valid,
  input  logic             pop_ready,
  output b85_pkg::job_t    pop_job
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [PtrW-1:0] PtrOne  = PtrW'(1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  b85_pkg::job_t         mem [DEPTH];
  logic [PtrW-1:0]       wr_r, wr_nxt;
  logic [PtrW-1:0]       rd_r, rd_nxt;
  logic [CntW-1:0]       cnt_r, cnt_nxt;
  logic                  do_push;
  logic                  do_pop;

  assign push_ready = (cnt_r != CntFull);
  assign pop_valid  = (cnt_r != '0);
  assign pop_job    = mem[rd_r];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  always_comb begin
    wr_nxt  = do_push ? ((wr_r == PtrLast) ? '0 : wr_r + PtrOne) : wr_r;
    rd_nxt  = do_pop ? ((rd_r == PtrLast) ? '0 : rd_r + PtrOne) : rd_r;
    cnt_nxt = cnt_r + CntW'(do_push) - CntW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> rtl/b85_back.sv
module b85_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  b85_pkg::job_t    pop_job,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte,
  output logic             out_byte_valid,
  output logic             out_frame_done,
  output logic [1:0]       out_status
);

  b85_pkg::job_t job_r;
  logic          busy_r, busy_nxt;
  logic [1:0]    idx_r, idx_nxt;
  logic          last;
  logic          done;
  logic          load;
  logic [7:0]    sel;

  assign last      = ({1'b0, idx_r} + 3'd1 == job_r.nbytes);
  assign done      = busy_r & out_ready & last;
  assign pop_ready = ~busy_r | done;
  assign load      = pop_valid & pop_ready;

  always_comb begin
    case (idx_r)
      2'd0:    sel = job_r.word[31:24];
      2'd1:    sel = job_r.word[23:16];
      2'd2:    sel = job_r.word[15:8];
      default: sel = job_r.word[7:0];
    endcase
    busy_nxt = load | (busy_r & ~done);
    if (load || done) idx_nxt = 2'd0;
    else if (busy_r && out_ready) idx_nxt = idx_r + 2'd1;
    else idx_nxt = idx_r;
  end

  assign out_valid      = busy_r;
  assign out_byte       = job_r.bare ? 8'd0 : sel;
  assign out_byte_valid = ~job_r.bare;
  assign out_frame_done = job_r.bare | (job_r.fin & last);
  assign out_status     = job_r.status;

  always_ff @(posedge clk) begin
    if (load) begin
      job_r <= pop_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 2'd0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

endmodule

>>> rtl/base85_stream_decoder_core.sv
// Base85 frame decoder, one character per request on the input channel.
// Input: in_char_in with in_frame_end marking the last character of a frame,
// which must be the two-character suffix ('~' then '~', '0', '1' or '2').
// Output: one byte per request, most significant first; out_frame_done marks
// the last request of a frame and out_status carries its status. A frame
// with errors ends in a single request with out_byte_valid low.
// Throughput: one input character per cycle sustained; every fifth data
// character yields a job of up to four bytes (none after an invalid
// character) and the output side drains one byte per cycle, so the input
// never waits while the receiver keeps pace. A job is written to the queue
// at the edge that folds the last digit of its block (the accept of the
// character two places later, or of the frame end); the output stage loads
// it from the queue once free and then presents the job's first byte.
// When the receiver stalls, the output holds and jobs collect in the queue
// (QUEUE_DEPTH entries); in_ready drops only when the queue is full.
// Reset clears the decode state, the queue and the output stage; the block
// accepts input in the first cycle after reset.
module base85_stream_decoder_core #(
  parameter int unsigned QUEUE_DEPTH = b85_pkg::QueueDepthDefault
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char_in,
  input  logic       in_frame_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_frame_done,
  output logic [1:0] out_status
);

  logic          push_valid;
  logic          push_ready;
  b85_pkg::job_t push_job;
  logic          pop_valid;
  logic          pop_ready;
  b85_pkg::job_t pop_job;

  b85_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char_in   (in_char_in),
    .in_frame_end (in_frame_end),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_job     (push_job)
  );

  b85_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  b85_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .pop_valid      (pop_valid),
    .pop_ready      (pop_ready),
    .pop_job        (pop_job),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_frame_done (out_frame_done),
    .out_status     (out_status)
  );

endmodule
